>>> design/stft_power_spectrum_frames_macros.svh
// assertion helpers for the checker module
`ifndef STFT_POWER_SPECTRUM_FRAMES_MACROS_SVH
`define STFT_POWER_SPECTRUM_FRAMES_MACROS_SVH

// same-cycle implication, quiet while reset is low
`define STFTPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is low
`define STFTPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/stftps_pkg.sv
`default_nettype none

package stftps_pkg;

    // sizes
    localparam int FFT_SIZE_DEF = 64;
    localparam int RING_AW      = 6;
    localparam int SAMPLE_W     = 16;
    localparam int DATA_W       = 26;
    localparam int TW_W         = 17;
    localparam int ACC_W        = 53;
    localparam int POS_W        = 35;
    localparam int POWER_W      = 44;
    localparam int LEN_W        = 7;
    localparam int SEEN_W       = 32;
    localparam int FRAME_W      = 16;
    localparam int BIN_W        = 6;
    localparam int CFG_IDX_W    = 2;

    // request codes
    localparam logic [1:0] REQ_COEF   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN = 2'd1;

    // command from the frame scheduler to the engine
    typedef struct packed {
        logic                       frame;
        logic                       nomore;
        logic signed [POS_W-1:0]    start;
        logic [LEN_W-1:0]           win;
        logic [SEEN_W-1:0]          seen;
        logic [FRAME_W-1:0]         idx;
    } t_cmd;

    // window table and sample ring writes
    typedef struct packed {
        logic                       win_we;
        logic [RING_AW-1:0]         win_addr;
        logic signed [SAMPLE_W-1:0] win_data;
        logic                       ring_we;
        logic [RING_AW-1:0]         ring_addr;
        logic signed [SAMPLE_W-1:0] ring_data;
    } t_mem_wr;

    typedef struct packed {
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
    } t_twiddle;

    // cos(2*pi*k/64) in signed q2.15, k = 0..16
    function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] k);
        logic signed [TW_W-1:0] v;
        case (k)
            5'd0:    v = 17'sd32768;
            5'd1:    v = 17'sd32610;
            5'd2:    v = 17'sd32138;
            5'd3:    v = 17'sd31357;
            5'd4:    v = 17'sd30274;
            5'd5:    v = 17'sd28899;
            5'd6:    v = 17'sd27246;
            5'd7:    v = 17'sd25330;
            5'd8:    v = 17'sd23170;
            5'd9:    v = 17'sd20788;
            5'd10:   v = 17'sd18205;
            5'd11:   v = 17'sd15447;
            5'd12:   v = 17'sd12540;
            5'd13:   v = 17'sd9512;
            5'd14:   v = 17'sd6393;
            5'd15:   v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // twiddle for angle index t of 64
    function automatic t_twiddle twiddle(input logic [4:0] t);
        t_twiddle r;
        if (t <= 5'd16) begin
            r.c = quarter_cos(t);
            r.s = quarter_cos(5'd16 - t);
        end else begin
            r.c = -quarter_cos(5'(6'd32 - 6'(t)));
            r.s = quarter_cos(t - 5'd16);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/stft_power_spectrum_frames.sv
// STFT power spectrum. Items are window coefficient writes, audio samples
// and flushes. A coefficient write, or a sample that completes no frame, is
// taken without a stall. An item that produces a frame holds the input
// stalled while one shared multiplier works through it: it windows and loads
// FFT_SIZE points (read, multiply, write), runs (FFT_SIZE/2)*log2(FFT_SIZE)
// butterflies, then emits FFT_SIZE/2+1 bins, each held while the output is
// stalled. A flush with no frame left gives one no_more_frames beat and
// restarts the stream. Power values are re*re+im*im kept to 44 bits.

`default_nettype none

module stft_power_spectrum_frames #(
    parameter int FFT_SIZE = stftps_pkg::FFT_SIZE_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_stall,
    input  wire logic [1:0]                              i_req_type,
    input  wire logic [5:0]                              i_coef_index,
    input  wire logic signed [15:0]                      i_coef_value,
    input  wire logic signed [15:0]                      i_sample,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_stall,
    output logic [5:0]                                   o_bin_index,
    output logic [43:0]                                  o_power,
    output logic [15:0]                                  o_frame_index,
    output logic                                         o_last_bin,
    output logic                                         o_no_more_frames,
    input  wire logic                                    i_cfg_we,
    input  wire logic [stftps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [stftps_pkg::LEN_W-1:0]            i_cfg_data
);

    localparam int POS_W  = stftps_pkg::POS_W;
    localparam int LEN_W  = stftps_pkg::LEN_W;
    localparam int SEEN_W = stftps_pkg::SEEN_W;
    localparam logic [LEN_W-1:0] WIN_MAX = LEN_W'(FFT_SIZE);

    logic [LEN_W-1:0]               r_hop, n_hop, r_win, n_win;
    logic [SEEN_W-1:0]              r_seen, n_seen;
    logic signed [POS_W-1:0]        r_nfs, n_nfs;
    logic [stftps_pkg::FRAME_W-1:0] r_fcnt, n_fcnt;

    logic                    busy, accept;
    logic [LEN_W-1:0]        eff_hop, eff_win;
    logic signed [POS_W-1:0] hop_x, win_x, reload, seen_x, seen_new_x;
    logic [SEEN_W-1:0]       seen_new;
    stftps_pkg::t_cmd        cmd;
    stftps_pkg::t_mem_wr     wr;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    // register writes
    always_comb begin
        n_hop = r_hop;
        n_win = r_win;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                stftps_pkg::CFG_HOP: n_hop = i_cfg_data;
                stftps_pkg::CFG_WIN: n_win = i_cfg_data;
                default: begin
                    n_hop = r_hop;
                    n_win = r_win;
                end
            endcase
        end
    end

    // effective hop and window, first frame start
    assign eff_hop = (n_hop == '0) ? LEN_W'(1) : n_hop;
    assign eff_win = (n_win > WIN_MAX) ? WIN_MAX : n_win;
    assign hop_x   = POS_W'(eff_hop);
    assign win_x   = POS_W'(eff_win);
    assign reload  = hop_x - win_x;

    assign seen_new   = (r_seen == '1) ? r_seen : r_seen + SEEN_W'(1);
    assign seen_x     = POS_W'(r_seen);
    assign seen_new_x = POS_W'(seen_new);

    // frame scheduling per accepted beat
    always_comb begin
        n_seen        = r_seen;
        n_nfs         = r_nfs;
        n_fcnt        = r_fcnt;
        cmd.frame     = 1'b0;
        cmd.nomore    = 1'b0;
        cmd.start     = r_nfs;
        cmd.win       = eff_win;
        cmd.seen      = r_seen;
        cmd.idx       = r_fcnt;
        wr.win_we     = 1'b0;
        wr.win_addr   = i_coef_index;
        wr.win_data   = i_coef_value;
        wr.ring_we    = 1'b0;
        wr.ring_addr  = r_seen[stftps_pkg::RING_AW-1:0];
        wr.ring_data  = i_sample;
        if (i_cfg_we && r_seen == '0 && r_fcnt == '0) begin
            n_nfs = reload;
        end
        if (accept) begin
            unique case (i_req_type)
                stftps_pkg::REQ_COEF: begin
                    wr.win_we = 1'b1;
                end
                stftps_pkg::REQ_SAMPLE: begin
                    wr.ring_we = (r_seen != '1);
                    n_seen     = seen_new;
                    cmd.seen   = seen_new;
                    if ((r_nfs + win_x) <= seen_new_x) begin
                        cmd.frame = 1'b1;
                        n_nfs     = r_nfs + hop_x;
                        n_fcnt    = r_fcnt + 16'd1;
                    end
                end
                stftps_pkg::REQ_FLUSH: begin
                    if (r_nfs < seen_x) begin
                        cmd.frame = 1'b1;
                        n_nfs     = r_nfs + hop_x;
                        n_fcnt    = r_fcnt + 16'd1;
                    end else begin
                        cmd.nomore = 1'b1;
                        n_seen     = '0;
                        n_fcnt     = '0;
                        n_nfs      = reload;
                    end
                end
                default: begin
                    cmd.frame = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop  <= LEN_W'(32);
            r_win  <= LEN_W'(64);
            r_seen <= '0;
            r_fcnt <= '0;
            r_nfs  <= POS_W'(32) - POS_W'((FFT_SIZE < 64) ? FFT_SIZE : 64);
        end else begin
            r_hop  <= n_hop;
            r_win  <= n_win;
            r_seen <= n_seen;
            r_fcnt <= n_fcnt;
            r_nfs  <= n_nfs;
        end
    end

    stftps_engine #(
        .FFT_SIZE(FFT_SIZE)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_wr             (wr),
        .o_busy           (busy),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_bin_index      (o_bin_index),
        .o_power          (o_power),
        .o_frame_index    (o_frame_index),
        .o_last_bin       (o_last_bin),
        .o_no_more_frames (o_no_more_frames)
    );

endmodule

`default_nettype wire

>>> design/stftps_engine.sv
`default_nettype none

module stftps_engine #(
    parameter int FFT_SIZE = stftps_pkg::FFT_SIZE_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire stftps_pkg::t_cmd                     i_cmd,
    input  wire stftps_pkg::t_mem_wr                  i_wr,
    output logic                                      o_busy,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [stftps_pkg::BIN_W-1:0]              o_bin_index,
    output logic [stftps_pkg::POWER_W-1:0]            o_power,
    output logic [stftps_pkg::FRAME_W-1:0]            o_frame_index,
    output logic                                      o_last_bin,
    output logic                                      o_no_more_frames
);

    localparam int AW    = $clog2(FFT_SIZE);
    localparam int ST_W  = $clog2(AW);
    localparam int HALF  = FFT_SIZE / 2;
    localparam int D     = stftps_pkg::DATA_W;
    localparam int ACC_W = stftps_pkg::ACC_W;
    localparam int POS_W = stftps_pkg::POS_W;
    localparam int LEN_W = stftps_pkg::LEN_W;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(16384);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LD_RD  = 4'd1;
    localparam logic [3:0] S_LD_MUL = 4'd2;
    localparam logic [3:0] S_LD_WR  = 4'd3;
    localparam logic [3:0] S_BF0    = 4'd4;
    localparam logic [3:0] S_BF1    = 4'd5;
    localparam logic [3:0] S_BF2    = 4'd6;
    localparam logic [3:0] S_BF3    = 4'd7;
    localparam logic [3:0] S_BF4    = 4'd8;
    localparam logic [3:0] S_BF5    = 4'd9;
    localparam logic [3:0] S_BF6    = 4'd10;
    localparam logic [3:0] S_BF7    = 4'd11;
    localparam logic [3:0] S_PW_RD  = 4'd12;
    localparam logic [3:0] S_PW_M1  = 4'd13;
    localparam logic [3:0] S_PW_M2  = 4'd14;
    localparam logic [3:0] S_EMIT   = 4'd15;

    // control registers
    logic [3:0]      r_state, n_state;
    logic [AW-1:0]   r_n, n_n;
    logic [AW-2:0]   r_bf, n_bf;
    logic [ST_W-1:0] r_st, n_st;
    logic [AW-1:0]   r_k, n_k;
    logic            r_out_valid, n_out_valid;
    logic [63:0]     r_win_vld;

    // frame and datapath registers
    logic signed [POS_W-1:0]   r_start, n_start;
    logic [LEN_W-1:0]          r_win, n_win;
    logic [stftps_pkg::SEEN_W-1:0]  r_seen, n_seen;
    logic [stftps_pkg::FRAME_W-1:0] r_idx, n_idx;
    logic                      r_ldok, n_ldok;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [D-1:0]       r_br, n_br, r_bi, n_bi, r_ar, n_ar, r_ai, n_ai;
    logic signed [D-1:0]       r_tr, n_tr, r_ti, n_ti;
    logic [stftps_pkg::BIN_W-1:0]   r_o_bin, n_o_bin;
    logic [stftps_pkg::POWER_W-1:0] r_o_power, n_o_power;
    logic [stftps_pkg::FRAME_W-1:0] r_o_frame, n_o_frame;
    logic                      r_o_last, n_o_last, r_o_nomore, n_o_nomore;

    // memories
    logic signed [15:0]  r_win_mem [64];
    logic signed [15:0]  r_ring [64];
    logic [2*D-1:0]      r_fft [FFT_SIZE];
    logic signed [15:0]  r_win_q, r_ring_q;
    logic                r_win_vq;
    logic [2*D-1:0]      r_fft_q;

    // comb signals
    logic signed [POS_W-1:0] pos;
    logic                    ld_ok;
    logic [AW-1:0]           rev;
    logic [AW-1:0]           bfx, half_m, half_b, j, ia, ib;
    logic [4:0]              tw_t;
    stftps_pkg::t_twiddle    tw;
    logic [AW-1:0]           rd_addr;
    logic signed [D-1:0]     fq_re, fq_im;
    logic signed [D-1:0]     mul_a, mul_b;
    logic signed [2*D-1:0]   prod;
    logic signed [ACC_W-1:0] prod_x, sum_add, sum_sub, rnd_acc, rnd_add, rnd_sub;
    logic                    fft_we;
    logic [AW-1:0]           fft_wa;
    logic [2*D-1:0]          fft_wd;

    assign o_busy           = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_bin_index      = r_o_bin;
    assign o_power          = r_o_power;
    assign o_frame_index    = r_o_frame;
    assign o_last_bin       = r_o_last;
    assign o_no_more_frames = r_o_nomore;

    // frame position of the current load element
    assign pos   = r_start + POS_W'(r_n);
    assign ld_ok = (LEN_W'(r_n) < r_win) && !pos[POS_W-1]
                   && (pos < $signed(POS_W'(r_seen)));

    // bit-reversed load address
    always_comb begin
        rev = '0;
        for (int b = 0; b < AW; b++) begin
            rev[AW-1-b] = r_n[b];
        end
    end

    // butterfly addressing and twiddle
    assign bfx    = AW'(r_bf);
    assign half_b = AW'(1) << r_st;
    assign half_m = half_b - AW'(1);
    assign j      = bfx & half_m;
    assign ia     = ((bfx & ~half_m) << 1) | j;
    assign ib     = ia | half_b;
    assign tw_t   = 5'((11'(j) << 5) >> r_st);
    assign tw     = stftps_pkg::twiddle(tw_t);

    // work memory read address
    always_comb begin
        rd_addr = r_k;
        if (r_state == S_BF0) begin
            rd_addr = ib;
        end else if (r_state >= S_BF1 && r_state <= S_BF7) begin
            rd_addr = ia;
        end
    end

    assign fq_re = r_fft_q[2*D-1:D];
    assign fq_im = r_fft_q[D-1:0];

    // shared multiplier and accumulator
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_LD_MUL: begin
                mul_a = D'(r_ring_q);
                mul_b = r_win_vq ? D'(r_win_q) : '0;
            end
            S_BF2: begin
                mul_a = r_br;
                mul_b = D'(tw.c);
            end
            S_BF3: begin
                mul_a = r_bi;
                mul_b = D'(tw.s);
            end
            S_BF4: begin
                mul_a = r_bi;
                mul_b = D'(tw.c);
            end
            S_BF5: begin
                mul_a = r_br;
                mul_b = D'(tw.s);
            end
            S_PW_M1: begin
                mul_a = fq_re;
                mul_b = fq_re;
            end
            S_PW_M2: begin
                mul_a = fq_im;
                mul_b = fq_im;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_x  = ACC_W'(prod);
    assign sum_add = r_acc + prod_x;
    assign sum_sub = r_acc - prod_x;
    // round half up after q1.15 product
    assign rnd_acc = (r_acc + RND) >>> 15;
    assign rnd_add = (sum_add + RND) >>> 15;
    assign rnd_sub = (sum_sub + RND) >>> 15;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_bf        = r_bf;
        n_st        = r_st;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_start     = r_start;
        n_win       = r_win;
        n_seen      = r_seen;
        n_idx       = r_idx;
        n_ldok      = r_ldok;
        n_acc       = r_acc;
        n_br        = r_br;
        n_bi        = r_bi;
        n_ar        = r_ar;
        n_ai        = r_ai;
        n_tr        = r_tr;
        n_ti        = r_ti;
        n_o_bin     = r_o_bin;
        n_o_power   = r_o_power;
        n_o_frame   = r_o_frame;
        n_o_last    = r_o_last;
        n_o_nomore  = r_o_nomore;
        fft_we      = 1'b0;
        fft_wa      = rev;
        fft_wd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.frame) begin
                    n_start = i_cmd.start;
                    n_win   = i_cmd.win;
                    n_seen  = i_cmd.seen;
                    n_idx   = i_cmd.idx;
                    n_n     = '0;
                    n_state = S_LD_RD;
                end else if (i_cmd.nomore) begin
                    n_o_bin     = '0;
                    n_o_power   = '0;
                    n_o_frame   = '0;
                    n_o_last    = 1'b0;
                    n_o_nomore  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_LD_RD: begin
                n_ldok  = ld_ok;
                n_state = S_LD_MUL;
            end
            S_LD_MUL: begin
                n_acc   = r_ldok ? prod_x : '0;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                fft_we = 1'b1;
                fft_wa = rev;
                fft_wd = {D'(rnd_acc), {D{1'b0}}};
                if (r_n == AW'(FFT_SIZE - 1)) begin
                    n_bf    = '0;
                    n_st    = '0;
                    n_state = S_BF0;
                end else begin
                    n_n     = r_n + AW'(1);
                    n_state = S_LD_RD;
                end
            end
            S_BF0: begin
                n_state = S_BF1;
            end
            S_BF1: begin
                n_br    = fq_re;
                n_bi    = fq_im;
                n_state = S_BF2;
            end
            S_BF2: begin
                n_ar    = fq_re;
                n_ai    = fq_im;
                n_acc   = prod_x;
                n_state = S_BF3;
            end
            S_BF3: begin
                n_tr    = D'(rnd_add);
                n_state = S_BF4;
            end
            S_BF4: begin
                n_acc   = prod_x;
                n_state = S_BF5;
            end
            S_BF5: begin
                n_ti    = D'(rnd_sub);
                n_state = S_BF6;
            end
            S_BF6: begin
                fft_we  = 1'b1;
                fft_wa  = ia;
                fft_wd  = {r_ar + r_tr, r_ai + r_ti};
                n_state = S_BF7;
            end
            S_BF7: begin
                fft_we = 1'b1;
                fft_wa = ib;
                fft_wd = {r_ar - r_tr, r_ai - r_ti};
                if (r_bf == (AW-1)'(HALF - 1)) begin
                    n_bf = '0;
                    if (r_st == ST_W'(AW - 1)) begin
                        n_k     = '0;
                        n_state = S_PW_RD;
                    end else begin
                        n_st    = r_st + ST_W'(1);
                        n_state = S_BF0;
                    end
                end else begin
                    n_bf    = r_bf + (AW-1)'(1);
                    n_state = S_BF0;
                end
            end
            S_PW_RD: begin
                n_state = S_PW_M1;
            end
            S_PW_M1: begin
                n_acc   = prod_x;
                n_state = S_PW_M2;
            end
            S_PW_M2: begin
                n_o_bin     = stftps_pkg::BIN_W'(r_k);
                n_o_power   = sum_add[stftps_pkg::POWER_W-1:0];
                n_o_frame   = r_idx;
                n_o_last    = (r_k == AW'(HALF));
                n_o_nomore  = 1'b0;
                n_out_valid = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_o_last || r_o_nomore) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_PW_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_bf        <= '0;
            r_st        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_win_vld   <= '0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_bf        <= n_bf;
            r_st        <= n_st;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_wr.win_we) begin
                r_win_vld[i_wr.win_addr] <= 1'b1;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_win      <= n_win;
        r_seen     <= n_seen;
        r_idx      <= n_idx;
        r_ldok     <= n_ldok;
        r_acc      <= n_acc;
        r_br       <= n_br;
        r_bi       <= n_bi;
        r_ar       <= n_ar;
        r_ai       <= n_ai;
        r_tr       <= n_tr;
        r_ti       <= n_ti;
        r_o_bin    <= n_o_bin;
        r_o_power  <= n_o_power;
        r_o_frame  <= n_o_frame;
        r_o_last   <= n_o_last;
        r_o_nomore <= n_o_nomore;
    end

    // window table
    always_ff @(posedge i_clk) begin
        if (i_wr.win_we) begin
            r_win_mem[i_wr.win_addr] <= i_wr.win_data;
        end
        r_win_q  <= r_win_mem[6'(r_n)];
        r_win_vq <= r_win_vld[6'(r_n)];
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (i_wr.ring_we) begin
            r_ring[i_wr.ring_addr] <= i_wr.ring_data;
        end
        r_ring_q <= r_ring[pos[stftps_pkg::RING_AW-1:0]];
    end

    // fft work memory
    always_ff @(posedge i_clk) begin
        if (fft_we) begin
            r_fft[fft_wa] <= fft_wd;
        end
        r_fft_q <= r_fft[rd_addr];
    end

endmodule

`default_nettype wire

>>> design/stftps_chk.sv
`default_nettype none

`include "stft_power_spectrum_frames_macros.svh"

module stftps_chk #(
    parameter int FFT_SIZE = stftps_pkg::FFT_SIZE_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [5:0]  o_bin_index,
    input wire logic [43:0] o_power,
    input wire logic        o_last_bin,
    input wire logic        o_no_more_frames
);

    localparam logic [5:0] BIN_LAST = 6'(FFT_SIZE / 2);

    // a waiting beat stays offered
    `STFTPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "out beat dropped while stalled")

    // no input beat taken while a result waits
    `STFTPS_ASSERT_IMP(a_in_blocked, i_clk, i_rst_n, o_out_valid, o_in_stall, "input open while result pending")

    // end-of-stream beat carries an empty payload
    `STFTPS_ASSERT_IMP(a_nomore_zero, i_clk, i_rst_n, o_out_valid && o_no_more_frames, o_power == 44'd0 && o_bin_index == 6'd0 && !o_last_bin, "no_more beat with payload")

    // last flag only on the top bin
    `STFTPS_ASSERT_IMP(a_last_pos, i_clk, i_rst_n, o_out_valid && o_last_bin, o_bin_index == BIN_LAST, "last_bin on wrong bin")

    // a frame in progress keeps the input closed
    `STFTPS_ASSERT_NXT(a_frame_busy, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last_bin && !o_no_more_frames, o_in_stall, "input opened inside a frame")

endmodule

bind stft_power_spectrum_frames stftps_chk #(
    .FFT_SIZE(FFT_SIZE)
) u_stftps_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_bin_index      (o_bin_index),
    .o_power          (o_power),
    .o_last_bin       (o_last_bin),
    .o_no_more_frames (o_no_more_frames)
);

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFFT  = 64;
    localparam int NBINS = NFFT / 2 + 1;
    // request code that the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // one expected output beat
    typedef struct packed {
        logic [5:0]  bin;
        logic [43:0] pwr;
        logic [15:0] fidx;
        logic        last;
        logic        nomore;
    } t_beat;

    // one input beat, with an optional typed-in first expected beat
    typedef struct {
        logic [1:0]  req;
        logic [5:0]  cidx;
        logic [15:0] cval;
        logic [15:0] smp;
        bit          has_exp;
        t_beat       exp_first;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    wire logic   in_stall;
    logic [1:0]  req_type;
    logic [5:0]  coef_index;
    logic [15:0] coef_value;
    logic [15:0] sample;
    wire logic   out_valid;
    logic        out_stall;
    wire logic [5:0]  bin_index;
    wire logic [43:0] power;
    wire logic [15:0] frame_index;
    wire logic   last_bin;
    wire logic   no_more;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    stft_power_spectrum_frames u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_coef_index(coef_index),
        .i_coef_value(coef_value), .i_sample(sample),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_bin_index(bin_index), .o_power(power), .o_frame_index(frame_index),
        .o_last_bin(last_bin), .o_no_more_frames(no_more),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // spectrogram state mirror
    logic [6:0]         hop_reg, win_reg;
    logic signed [15:0] win_coef [64];
    logic signed [15:0] ring [64];
    logic [31:0]        seen;
    longint             frame_start;
    logic [15:0]        frame_cnt;
    longint             wre [64];
    longint             wim [64];

    t_beat  spectrum_q [$];
    t_beat  typed_q [$];
    int     errors;
    int     beats_seen;
    int     frames_seen;
    int     nomore_seen;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("stft_power_spectrum_frames verification failed");
        $finish;
    end

    function automatic longint hop_eff();
        return (hop_reg == 0) ? 1 : longint'(hop_reg);
    endfunction

    function automatic longint win_eff();
        return (win_reg > NFFT) ? NFFT : longint'(win_reg);
    endfunction

    // floor(v / 2^k + 1/2)
    function automatic longint rnd_shift(longint v, int k);
        longint q;
        q = v + (longint'(1) << (k - 1));
        return q >>> k;
    endfunction

    function automatic longint qcos(int k);
        int tbl [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                         23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        return tbl[k];
    endfunction

    task automatic stream_restart();
        for (int i = 0; i < 64; i++) ring[i] = '0;
        seen = '0;
        frame_cnt = '0;
        frame_start = hop_eff() - win_eff();
    endtask

    // window, fft and power of the pending frame
    task automatic predict_frame();
        longint x, p, c, sn, br, bi, tr, ti, ar, ai, re, im;
        int r, ia, ib, half, stride;
        t_beat b;
        for (int n = 0; n < NFFT; n++) begin
            x = 0;
            p = frame_start + n;
            if (n < win_eff() && p >= 0 && p < longint'(seen))
                x = rnd_shift(longint'(ring[p & 63]) * longint'(win_coef[n]), 15);
            r = 0;
            for (int bt = 0; bt < 6; bt++)
                if (n[bt]) r |= 1 << (5 - bt);
            wre[r] = x;
            wim[r] = 0;
        end
        for (int len = 2; len <= NFFT; len <<= 1) begin
            half = len >> 1;
            stride = 64 / len;
            for (int k = 0; k + len <= NFFT; k += len) begin
                for (int j = 0; j < half; j++) begin
                    r = (j * stride) & 31;
                    if (r <= 16) begin
                        c = qcos(r); sn = qcos(16 - r);
                    end else begin
                        c = -qcos(32 - r); sn = qcos(r - 16);
                    end
                    ia = k + j;
                    ib = k + j + half;
                    br = wre[ib]; bi = wim[ib];
                    tr = rnd_shift(br * c + bi * sn, 15);
                    ti = rnd_shift(bi * c - br * sn, 15);
                    ar = wre[ia]; ai = wim[ia];
                    wre[ia] = ar + tr; wim[ia] = ai + ti;
                    wre[ib] = ar - tr; wim[ib] = ai - ti;
                end
            end
        end
        for (int k = 0; k < NBINS; k++) begin
            re = wre[k]; im = wim[k];
            b.bin = 6'(k);
            b.pwr = 44'(re * re + im * im);
            b.fidx = frame_cnt;
            b.last = (k == NFFT / 2);
            b.nomore = 1'b0;
            spectrum_q.push_back(b);
        end
        frame_start += hop_eff();
        frame_cnt++;
    endtask

    task automatic predict_item(logic [1:0] rq, logic [5:0] ci, logic [15:0] cv,
                                logic [15:0] sm);
        t_beat b;
        case (rq)
            stftps_pkg::REQ_COEF: win_coef[ci] = cv;
            stftps_pkg::REQ_SAMPLE: begin
                if (seen != 32'hFFFF_FFFF) begin
                    ring[seen[5:0]] = sm;
                    seen++;
                end
                if (frame_start + win_eff() <= longint'(seen)) predict_frame();
            end
            stftps_pkg::REQ_FLUSH: begin
                if (frame_start < longint'(seen)) begin
                    predict_frame();
                end else begin
                    stream_restart();
                    b = '0;
                    b.nomore = 1'b1;
                    spectrum_q.push_back(b);
                end
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == stftps_pkg::CFG_HOP) hop_reg = val;
        else if (idx == stftps_pkg::CFG_WIN) win_reg = val;
        if (seen == 0 && frame_cnt == 0) frame_start = hop_eff() - win_eff();
    endtask

    // drive one input beat and hold it until accepted
    task automatic send_item(logic [1:0] rq, logic [5:0] ci, logic [15:0] cv,
                             logic [15:0] sm);
        in_valid = 1'b1;
        req_type = rq;
        coef_index = ci;
        coef_value = cv;
        sample = sm;
        predict_item(rq, ci, cv, sm);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // bursts of beats with random gaps
    int burst_left;
    task automatic pace();
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // wait for the queue to drain, then a quiet period for a trailing frame
    task automatic drain();
        in_valid = 1'b0;
        while (spectrum_q.size() != 0) @(negedge clk);
        repeat (2500) @(negedge clk);
    endtask

    // receiver stall pattern
    int stall_mode;
    always @(negedge clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // output check against the oldest expected beat
    always @(posedge clk) begin
        t_beat got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = {bin_index, power, frame_index, last_bin, no_more};
            beats_seen++;
            if (no_more) nomore_seen++;
            if (last_bin) frames_seen++;
            if (spectrum_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat %h", $realtime, got);
            end else begin
                want = spectrum_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t mismatch exp bin %0d pwr %0d frame %0d last %b nm %b",
                             $realtime, want.bin, want.pwr, want.fidx, want.last,
                             want.nomore);
                    $display("%0t          got bin %0d pwr %0d frame %0d last %b nm %b",
                             $realtime, got.bin, got.pwr, got.fidx, got.last, got.nomore);
                end
                if (typed_q.size() != 0 && want.nomore) begin
                    if (got !== typed_q[0]) begin
                        errors++;
                        $display("%0t typed mismatch exp %h got %h", $realtime,
                                 typed_q[0], got);
                    end
                    void'(typed_q.pop_front());
                end
            end
        end
    end

    t_row rows [$];

    task automatic add_row(logic [1:0] rq, logic [5:0] ci, logic [15:0] cv,
                           logic [15:0] sm, bit he);
        t_row r;
        r.req = rq; r.cidx = ci; r.cval = cv; r.smp = sm; r.has_exp = he;
        r.exp_first = '0;
        r.exp_first.nomore = he;
        rows.push_back(r);
    endtask

    // random sample value biased to extremes
    function automatic logic [15:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    int n_items;
    initial begin
        logic [1:0] rq;
        errors = 0; beats_seen = 0; frames_seen = 0; nomore_seen = 0;
        burst_left = 0; stall_mode = 0;
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
        req_type = stftps_pkg::REQ_COEF; coef_index = '0; coef_value = '0; sample = '0;
        cfg_we = 1'b0; cfg_index = stftps_pkg::CFG_HOP; cfg_data = '0;
        hop_reg = 7'd32; win_reg = 7'd64;
        for (int i = 0; i < 64; i++) win_coef[i] = '0;
        stream_restart();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: flush on empty stream, extremes, ignored code, short frames
        add_row(stftps_pkg::REQ_FLUSH, 0, 0, 0, 1);
        add_row(stftps_pkg::REQ_COEF, 6'd0, 16'h7FFF, 0, 0);
        add_row(stftps_pkg::REQ_COEF, 6'd63, 16'h8000, 0, 0);
        add_row(stftps_pkg::REQ_COEF, 6'd1, 16'hFFFF, 0, 0);
        add_row(stftps_pkg::REQ_COEF, 6'd2, 16'h4000, 0, 0);
        add_row(REQ_UNUSED, 6'h3F, 16'hFFFF, 16'hFFFF, 0);
        foreach (rows[i]) begin
            if (rows[i].has_exp) typed_q.push_back(rows[i].exp_first);
            send_item(rows[i].req, rows[i].cidx, rows[i].cval, rows[i].smp);
        end
        drain();
        write_reg(stftps_pkg::CFG_HOP, 7'd2);
        write_reg(stftps_pkg::CFG_WIN, 7'd4);
        rows.delete();
        add_row(stftps_pkg::REQ_SAMPLE, 0, 0, 16'h7FFF, 0);
        add_row(stftps_pkg::REQ_SAMPLE, 0, 0, 16'h8000, 0);
        add_row(stftps_pkg::REQ_SAMPLE, 0, 0, 16'h8000, 0);
        add_row(stftps_pkg::REQ_SAMPLE, 0, 0, 16'h7FFF, 0);
        add_row(stftps_pkg::REQ_SAMPLE, 0, 0, 16'h5555, 0);
        add_row(stftps_pkg::REQ_FLUSH, 0, 0, 0, 0);
        add_row(stftps_pkg::REQ_FLUSH, 0, 0, 0, 0);
        add_row(stftps_pkg::REQ_FLUSH, 0, 0, 0, 0);
        add_row(stftps_pkg::REQ_FLUSH, 0, 0, 0, 0);
        foreach (rows[i]) send_item(rows[i].req, rows[i].cidx, rows[i].cval, rows[i].smp);
        drain();
        // window length zero and hop zero, then oversize window
        write_reg(stftps_pkg::CFG_WIN, 7'd0);
        write_reg(stftps_pkg::CFG_HOP, 7'd0);
        send_item(stftps_pkg::REQ_SAMPLE, 0, 0, 16'h1234);
        send_item(stftps_pkg::REQ_FLUSH, 0, 0, 0);
        drain();
        write_reg(stftps_pkg::CFG_WIN, 7'd127);
        write_reg(stftps_pkg::CFG_HOP, 7'd64);
        send_item(stftps_pkg::REQ_SAMPLE, 0, 0, 16'h7FFF);
        send_item(stftps_pkg::REQ_FLUSH, 0, 0, 0);
        send_item(stftps_pkg::REQ_FLUSH, 0, 0, 0);
        send_item(stftps_pkg::REQ_FLUSH, 0, 0, 0);
        drain();

        // random phases: mostly samples with a few coefs and flushes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(stftps_pkg::CFG_HOP, 7'd4);
                    write_reg(stftps_pkg::CFG_WIN, 7'd8);
                end
                1: begin
                    write_reg(stftps_pkg::CFG_HOP, 7'd1);
                    write_reg(stftps_pkg::CFG_WIN, 7'd1);
                end
                2: begin
                    write_reg(stftps_pkg::CFG_HOP, 7'd7);
                    write_reg(stftps_pkg::CFG_WIN, 7'd64);
                end
                default: begin
                    write_reg(stftps_pkg::CFG_HOP, 7'($urandom_range(1, 16)));
                    write_reg(stftps_pkg::CFG_WIN, 7'($urandom_range(1, 64)));
                end
            endcase
            // fill the whole window table once
            if (ph == 0) begin
                for (int i = 0; i < 64; i++)
                    send_item(stftps_pkg::REQ_COEF, 6'(i), rnd_val(), 16'($urandom));
            end
            n_items = 0;
            while (n_items < 15) begin
                pace();
                case ($urandom_range(0, 19))
                    0, 1: rq = stftps_pkg::REQ_COEF;
                    2:    rq = stftps_pkg::REQ_FLUSH;
                    3:    rq = REQ_UNUSED;
                    default: rq = stftps_pkg::REQ_SAMPLE;
                endcase
                send_item(rq, 6'($urandom), rnd_val(), rnd_val());
                if (rq != REQ_UNUSED) n_items++;
            end
            // flush out remaining frames until the stream restarts
            do send_item(stftps_pkg::REQ_FLUSH, 0, 0, 0);
            while (seen != 0);
            drain();
        end

        $display("covered %0d frames, %0d end-of-stream beats, %0d beats in all",
                 frames_seen, nomore_seen, beats_seen);
        if (errors == 0 && spectrum_q.size() == 0) begin
            $display("stft_power_spectrum_frames verification clean");
        end else begin
            $display("stft_power_spectrum_frames verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/stftps_pkg.sv
design/stftps_engine.sv
design/stft_power_spectrum_frames.sv
design/stftps_chk.sv
bench/tb.sv
